[hw/rtl/prr_pkg.sv]
package prr_pkg;

    // Item payload widths
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 18;
    localparam int COEF_ADDR_W = 9;
    localparam int HIST_W      = 2 * SAMPLE_W;
    localparam int PROD_W      = COEF_W + SAMPLE_W;
    localparam int FRAC_W      = 16;
    localparam int ROUND_HALF  = 32768;

    // Configuration registers
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int L_W        = 5;
    localparam int M_W        = 8;
    localparam int K_W        = 6;
    localparam int SKIP_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS   = 2'd2;

    localparam logic [L_W-1:0] L_RST = 5'd1;
    localparam logic [M_W-1:0] M_RST = 8'd1;
    localparam logic [K_W-1:0] K_RST = 6'd13;

    // Operation codes
    localparam logic OP_COEF = 1'b0;
    localparam logic OP_PUSH = 1'b1;

    // Output burst limit per pushed sample
    localparam int MAX_OUTS  = 16;
    localparam int OUT_CNT_W = 4;

    // Restoring divider for M / L, one quotient bit per cycle
    localparam int DIV_CW = $clog2(M_W);

    typedef logic signed [SAMPLE_W-1:0]    t_sample;
    typedef logic signed [COEF_W-1:0]      t_coef;
    typedef logic        [COEF_ADDR_W-1:0] t_coef_addr;

endpackage

[hw/rtl/prr_stream_if.sv]
interface prr_in_if;
    logic                 valid;
    logic                 ready;
    logic                 op;
    prr_pkg::t_coef_addr  coef_addr;
    prr_pkg::t_coef       coef_value;
    prr_pkg::t_sample     sample_i;
    prr_pkg::t_sample     sample_q;

    modport source (
        output valid, op, coef_addr, coef_value, sample_i, sample_q,
        input  ready
    );
    modport sink (
        input  valid, op, coef_addr, coef_value, sample_i, sample_q,
        output ready
    );
endinterface

interface prr_out_if;
    logic              valid;
    logic              ready;
    prr_pkg::t_sample  out_i;
    prr_pkg::t_sample  out_q;
    logic              clipped;
    logic              last;

    modport source (
        output valid, out_i, out_q, clipped, last,
        input  ready
    );
    modport sink (
        input  valid, out_i, out_q, clipped, last,
        output ready
    );
endinterface

[hw/rtl/polyphase_rational_resampler.sv]
// Polyphase rational resampler for complex I/Q samples, ratio L/M. Each input
// transaction either writes one Q2.16 tap (op = coefficient write, address
// branch * MAX_TAPS + tap) or pushes one sample; a push yields zero to sixteen
// output transactions, the final one flagged by last. Taps live in a
// coefficient memory with one write and one read port and the sample
// history in a circular memory of MAX_TAPS words; a fill count makes
// history slots that were never written read as zero, so no clearing pass
// is needed after reset. Taps must be written before they are used. A push
// that produces outputs is accepted, runs the M/L divider, then computes
// each output with a single I/Q multiply-accumulate pair that walks the
// coefficient and history memories one tap per cycle; a stalled output
// register holds back the load of the next output. The user must write
// configuration only while idle; the block itself does not enforce it.
module polyphase_rational_resampler #(
    parameter int MAX_TAPS     = 32,
    parameter int MAX_BRANCHES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    prr_in_if.sink                            i_in,
    prr_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [prr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [prr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int PTRW   = $clog2(MAX_TAPS);
    localparam int FILLW  = $clog2(MAX_TAPS + 1);
    localparam int PW     = (MAX_BRANCHES > 1) ? $clog2(MAX_BRANCHES) : 1;
    localparam int CDEPTH = MAX_BRANCHES * MAX_TAPS;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int AW     = prr_pkg::PROD_W + FILLW;
    localparam int QW     = AW - prr_pkg::FRAC_W;
    localparam int SW     = ((PW > prr_pkg::L_W) ? PW : prr_pkg::L_W) + 1;
    localparam int LW     = prr_pkg::L_W;
    localparam int MW     = prr_pkg::M_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_MAC   = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    localparam logic signed [AW-1:0] ROUND_C = AW'(prr_pkg::ROUND_HALF);
    localparam logic signed [QW-1:0] QMAX    = QW'(32767);
    localparam logic signed [QW-1:0] QMIN    = QW'(-32768);
    localparam logic [prr_pkg::DIV_CW-1:0] DIV_LAST = prr_pkg::DIV_CW'(MW - 1);
    localparam logic [prr_pkg::OUT_CNT_W-1:0] NOUT_LAST =
        prr_pkg::OUT_CNT_W'(prr_pkg::MAX_OUTS - 1);

    // Configuration registers: keep the written bits, clamp on use
    logic [LW-1:0]            r_interp;
    logic [MW-1:0]            r_decim;
    logic [prr_pkg::K_W-1:0]  r_taps;

    logic [LW-1:0]    w_l;
    logic [MW-1:0]    w_m;
    logic [FILLW-1:0] w_k;
    logic [PTRW-1:0]  w_k_m1;

    // Control state
    logic [1:0]                        r_state;
    logic [1:0]                        n_state;
    logic [PW-1:0]                     r_phase;
    logic [prr_pkg::SKIP_W-1:0]        r_skip;
    logic [PTRW-1:0]                   r_wptr;
    logic [FILLW-1:0]                  r_fill;
    logic                              r_ovalid;
    logic                              r_p1_v;
    logic                              r_p2_v;

    // Divider, sequencing and datapath
    logic [prr_pkg::DIV_CW-1:0]        r_div_cnt;
    logic [MW-1:0]                     r_dnum;
    logic [MW-1:0]                     r_quo;
    logic [LW-1:0]                     r_rem;
    logic [prr_pkg::OUT_CNT_W-1:0]     r_nout;
    logic [PTRW-1:0]                   r_age;
    logic [PTRW-1:0]                   r_tap;
    logic                              r_p1_hv;
    logic signed [prr_pkg::PROD_W-1:0] r_prod_i;
    logic signed [prr_pkg::PROD_W-1:0] r_prod_q;
    logic signed [AW-1:0]              r_acc_i;
    logic signed [AW-1:0]              r_acc_q;
    prr_pkg::t_sample                  r_out_i;
    prr_pkg::t_sample                  r_out_q;
    logic                              r_out_clip;
    logic                              r_out_last;

    // Memories
    logic [prr_pkg::HIST_W-1:0]        r_hist_mem [MAX_TAPS];
    logic [prr_pkg::HIST_W-1:0]        r_hist_rd;
    prr_pkg::t_coef                    r_coef_mem [CDEPTH];
    prr_pkg::t_coef                    r_coef_rd;

    logic             w_in_ready;
    logic             w_in_fire;
    logic             w_push;
    logic             w_push_go;
    logic             w_coef_wr;
    logic             w_div_done;
    logic             w_drained;
    logic             w_out_load;
    logic             w_start_out;
    logic [PTRW-1:0]  w_wptr_nxt;
    logic [PTRW-1:0]  w_hist_raddr;
    logic             w_hvalid;
    logic [PW-1:0]    w_phase_mod;
    logic [CAW-1:0]   w_base;
    logic [CAW-1:0]   w_coef_raddr;

    logic [LW:0]      w_trial;
    logic             w_ge;
    logic [LW:0]      w_trial_sub;

    logic [SW-1:0]    w_psum;
    logic             w_wrap;
    logic [PW-1:0]    w_pnext;
    logic [MW:0]      w_adv;
    logic             w_last;

    prr_pkg::t_sample                  w_hist_i;
    prr_pkg::t_sample                  w_hist_q;
    logic signed [prr_pkg::PROD_W-1:0] w_mul_i;
    logic signed [prr_pkg::PROD_W-1:0] w_mul_q;

    logic signed [AW-1:0] w_v_i;
    logic signed [AW-1:0] w_v_q;
    logic signed [QW-1:0] w_q_i;
    logic signed [QW-1:0] w_q_q;
    prr_pkg::t_sample     w_sat_i;
    prr_pkg::t_sample     w_sat_q;
    logic                 w_clip_i;
    logic                 w_clip_q;

    // Clamp the factors: L to 1..MAX_BRANCHES, M to at least 1, K to 1..MAX_TAPS
    always_comb begin
        if (r_interp == '0) begin
            w_l = LW'(1);
        end else if (32'(r_interp) > MAX_BRANCHES) begin
            w_l = LW'(MAX_BRANCHES);
        end else begin
            w_l = r_interp;
        end
        w_m = (r_decim == '0) ? MW'(1) : r_decim;
        if (r_taps == '0) begin
            w_k = FILLW'(1);
        end else if (32'(r_taps) > MAX_TAPS) begin
            w_k = FILLW'(MAX_TAPS);
        end else begin
            w_k = FILLW'(r_taps);
        end
    end
    assign w_k_m1 = PTRW'(w_k - FILLW'(1));

    // Handshake decode
    assign w_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in.valid && w_in_ready;
    assign w_push     = w_in_fire && (i_in.op == prr_pkg::OP_PUSH);
    assign w_push_go  = w_push && (r_skip == '0);
    assign w_coef_wr  = w_in_fire && (i_in.op == prr_pkg::OP_COEF) &&
                        (32'(i_in.coef_addr) < CDEPTH);
    assign w_div_done = (r_state == S_DIV) && (r_div_cnt == DIV_LAST);
    assign w_drained  = (r_state == S_DRAIN) && !r_p1_v && !r_p2_v;
    assign w_out_load = w_drained && (!r_ovalid || o_out.ready);
    assign w_start_out = w_div_done || (w_out_load && !w_last);

    // History addressing: newest sample at the write pointer, age counts back
    assign w_wptr_nxt = (32'(r_wptr) == MAX_TAPS - 1) ? '0 : r_wptr + PTRW'(1);
    assign w_hist_raddr = (r_age <= r_wptr) ? (r_wptr - r_age)
                        : PTRW'(32'(r_wptr) + MAX_TAPS - 32'(r_age));
    // Slots older than the fill count were never written and read as zero
    assign w_hvalid = (FILLW'(r_age) < r_fill);

    // Coefficient addressing: stale phases at or above MAX_BRANCHES wrap once
    assign w_phase_mod = (32'(r_phase) >= MAX_BRANCHES)
                       ? PW'(32'(r_phase) - MAX_BRANCHES) : r_phase;
    assign w_base       = CAW'(32'(w_phase_mod) * MAX_TAPS);
    assign w_coef_raddr = w_base + CAW'(r_tap);

    // One restoring step of M / L
    assign w_trial     = {r_rem, r_dnum[MW-1]};
    assign w_ge        = (w_trial >= {1'b0, w_l});
    assign w_trial_sub = w_trial - {1'b0, w_l};

    // Phase advance: add M mod L, carry once, move position by M / L + carry
    assign w_psum  = SW'(r_phase) + SW'(r_rem);
    assign w_wrap  = (w_psum >= SW'(w_l));
    assign w_pnext = PW'(w_wrap ? (w_psum - SW'(w_l)) : w_psum);
    assign w_adv   = {1'b0, r_quo} + (MW + 1)'(w_wrap);
    assign w_last  = (w_adv != '0) || (r_nout == NOUT_LAST);

    // Multiply history word by tap
    assign w_hist_i = $signed(r_hist_rd[prr_pkg::HIST_W-1:prr_pkg::SAMPLE_W]);
    assign w_hist_q = $signed(r_hist_rd[prr_pkg::SAMPLE_W-1:0]);
    assign w_mul_i  = r_coef_rd * w_hist_i;
    assign w_mul_q  = r_coef_rd * w_hist_q;

    // Round half up, floor to integer, saturate to 16 bits
    assign w_v_i = r_acc_i + ROUND_C;
    assign w_v_q = r_acc_q + ROUND_C;
    assign w_q_i = $signed(w_v_i[AW-1:prr_pkg::FRAC_W]);
    assign w_q_q = $signed(w_v_q[AW-1:prr_pkg::FRAC_W]);

    always_comb begin
        w_clip_i = 1'b0;
        w_clip_q = 1'b0;
        if (w_q_i > QMAX) begin
            w_sat_i  = prr_pkg::t_sample'(32767);
            w_clip_i = 1'b1;
        end else if (w_q_i < QMIN) begin
            w_sat_i  = prr_pkg::t_sample'(-32768);
            w_clip_i = 1'b1;
        end else begin
            w_sat_i = w_q_i[prr_pkg::SAMPLE_W-1:0];
        end
        if (w_q_q > QMAX) begin
            w_sat_q  = prr_pkg::t_sample'(32767);
            w_clip_q = 1'b1;
        end else if (w_q_q < QMIN) begin
            w_sat_q  = prr_pkg::t_sample'(-32768);
            w_clip_q = 1'b1;
        end else begin
            w_sat_q = w_q_q[prr_pkg::SAMPLE_W-1:0];
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_push_go) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (r_age == '0) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_out_load) begin
                    n_state = w_last ? S_IDLE : S_MAC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_interp <= prr_pkg::L_RST;
            r_decim  <= prr_pkg::M_RST;
            r_taps   <= prr_pkg::K_RST;
            r_phase  <= '0;
            r_skip   <= '0;
            r_wptr   <= '0;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
            r_p1_v   <= 1'b0;
            r_p2_v   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    prr_pkg::CFG_INTERP: r_interp <= i_cfg_data[LW-1:0];
                    prr_pkg::CFG_DECIM:  r_decim  <= i_cfg_data[MW-1:0];
                    prr_pkg::CFG_TAPS:   r_taps   <= i_cfg_data[prr_pkg::K_W-1:0];
                    default: ;
                endcase
            end

            // Advance the history ring; saturate the fill count at the depth
            if (w_push) begin
                r_wptr <= w_wptr_nxt;
                if (32'(r_fill) < MAX_TAPS) begin
                    r_fill <= r_fill + FILLW'(1);
                end
                if (r_skip != '0) begin
                    r_skip <= r_skip - prr_pkg::SKIP_W'(1);
                end
            end

            // MAC pipeline valids: issue, memory data, product
            r_p1_v <= (r_state == S_MAC);
            r_p2_v <= r_p1_v;

            if (w_out_load) begin
                r_ovalid <= 1'b1;
                r_phase  <= w_pnext;
                if (w_adv != '0) begin
                    r_skip <= prr_pkg::SKIP_W'(w_adv - (MW + 1)'(1));
                end
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Divider, tap counters, accumulators and output payload
    always_ff @(posedge i_clk) begin
        if (w_push_go) begin
            r_div_cnt <= '0;
            r_dnum    <= w_m;
            r_quo     <= '0;
            r_rem     <= '0;
        end else if (r_state == S_DIV) begin
            r_div_cnt <= r_div_cnt + prr_pkg::DIV_CW'(1);
            r_dnum    <= {r_dnum[MW-2:0], 1'b0};
            r_quo     <= {r_quo[MW-2:0], w_ge};
            r_rem     <= LW'(w_ge ? w_trial_sub : w_trial);
        end

        if (w_push_go) begin
            r_nout <= '0;
        end else if (w_out_load) begin
            r_nout <= r_nout + prr_pkg::OUT_CNT_W'(1);
        end

        // Walk taps upward and history ages downward
        if (w_start_out) begin
            r_age <= w_k_m1;
            r_tap <= '0;
        end else if (r_state == S_MAC) begin
            r_age <= r_age - PTRW'(1);
            r_tap <= r_tap + PTRW'(1);
        end
        r_p1_hv <= w_hvalid;

        if (r_p1_v) begin
            r_prod_i <= r_p1_hv ? w_mul_i : '0;
            r_prod_q <= r_p1_hv ? w_mul_q : '0;
        end

        if (w_start_out) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (r_p2_v) begin
            r_acc_i <= r_acc_i + AW'(r_prod_i);
            r_acc_q <= r_acc_q + AW'(r_prod_q);
        end

        if (w_out_load) begin
            r_out_i    <= w_sat_i;
            r_out_q    <= w_sat_q;
            r_out_clip <= w_clip_i || w_clip_q;
            r_out_last <= w_last;
        end
    end

    // Sample history memory: write the newest sample, read one age per cycle
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_hist_mem[w_wptr_nxt] <= {i_in.sample_i, i_in.sample_q};
        end
        r_hist_rd <= r_hist_mem[w_hist_raddr];
    end

    // Coefficient memory: drop writes beyond the store
    always_ff @(posedge i_clk) begin
        if (w_coef_wr) begin
            r_coef_mem[CAW'(i_in.coef_addr)] <= i_in.coef_value;
        end
        r_coef_rd <= r_coef_mem[w_coef_raddr];
    end

    assign i_in.ready    = w_in_ready;
    assign o_out.valid   = r_ovalid;
    assign o_out.out_i   = r_out_i;
    assign o_out.out_q   = r_out_q;
    assign o_out.clipped = r_out_clip;
    assign o_out.last    = r_out_last;

endmodule

[hw/rtl/prr_checker.sv]
module prr_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_out_last,
    input prr_pkg::t_sample i_out_i,
    input prr_pkg::t_sample i_out_q
);

    // An accepted transaction while no result is pending never shows a result in the next cycle
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) |=> !i_out_valid)
        else $error("result appeared one cycle after an input transaction");

    // More results pending for the current sample: hold off new input
    a_busy_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> !i_in_ready)
        else $error("input accepted while a burst of results is in progress");

    // A stalled result holds its value
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_i) && $stable(i_out_q)))
        else $error("stalled result dropped or changed");

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind polyphase_rational_resampler prr_checker u_prr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_last  (o_out.last),
    .i_out_i     (o_out.out_i),
    .i_out_q     (o_out.out_q)
);
